// ===== rtl/vaxr_pkg.sv =====
package vaxr_pkg;

  // internal binary angle: 2^32 is one turn
  localparam int TURN_W = 32;
  // CORDIC datapath widths (x/y in Q2.30 with headroom, z in turn units)
  localparam int CX_W = 34;
  localparam int CZ_W = 33;
  localparam int COEF_W = 32;

  localparam logic signed [CX_W-1:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [COEF_W-1:0] ONE_Q30 = 32'sd1073741824;
  localparam logic signed [COEF_W-1:0] ROUND_Q30 = 32'sd536870912;
  localparam logic [TURN_W-1:0] EIGHTH_TURN = 32'h2000_0000;

  localparam int ATAN_ENTRIES = 24;
  // atan(2^-i) in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef enum logic [1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  typedef enum logic [1:0] {
    QUAD_0   = 2'd0,
    QUAD_90  = 2'd1,
    QUAD_180 = 2'd2,
    QUAD_270 = 2'd3
  } quad_t;

  typedef struct packed {
    logic signed [CX_W-1:0] x;
    logic signed [CX_W-1:0] y;
    logic signed [CZ_W-1:0] z;
  } cordic_t;

endpackage

// ===== rtl/vaxr_if.sv =====
interface vaxr_in_if #(
  parameter int COORD_WIDTH = 32,
  parameter int ANGLE_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [ANGLE_WIDTH-1:0]        angle;
  logic signed [COORD_WIDTH-1:0] in_x;
  logic signed [COORD_WIDTH-1:0] in_y;
  logic signed [COORD_WIDTH-1:0] in_z;

  modport source (output valid, req_type, angle, in_x, in_y, in_z, input ready);
  modport sink (input valid, req_type, angle, in_x, in_y, in_z, output ready);
endinterface

interface vaxr_out_if #(
  parameter int COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] out_x;
  logic signed [COORD_WIDTH-1:0] out_y;
  logic signed [COORD_WIDTH-1:0] out_z;

  modport source (output valid, out_x, out_y, out_z, input ready);
  modport sink (input valid, out_x, out_y, out_z, output ready);
endinterface

// ===== rtl/vaxr_cordic_stage.sv =====
module vaxr_cordic_stage #(
  parameter int STAGE  = 0,
  parameter int META_W = 100
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  vaxr_pkg::cordic_t       in_vec,
  input  logic [META_W-1:0]       in_meta,
  output logic                    out_valid,
  input  logic                    out_ready,
  output vaxr_pkg::cordic_t       out_vec,
  output logic [META_W-1:0]       out_meta
);

  logic signed [vaxr_pkg::CX_W-1:0] dx;
  logic signed [vaxr_pkg::CX_W-1:0] dy;
  logic signed [vaxr_pkg::CZ_W-1:0] step;
  vaxr_pkg::cordic_t                vec_nxt;
  vaxr_pkg::cordic_t                vec_r;
  logic [META_W-1:0]                meta_r;
  logic                             valid_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    dx   = in_vec.y >>> STAGE;
    dy   = in_vec.x >>> STAGE;
    step = $signed(vaxr_pkg::CZ_W'(vaxr_pkg::ATAN_TURN32[STAGE]));
    if (!in_vec.z[vaxr_pkg::CZ_W-1]) begin
      vec_nxt.x = in_vec.x - dx;
      vec_nxt.y = in_vec.y + dy;
      vec_nxt.z = in_vec.z - step;
    end else begin
      vec_nxt.x = in_vec.x + dx;
      vec_nxt.y = in_vec.y - dy;
      vec_nxt.z = in_vec.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      vec_r  <= vec_nxt;
      meta_r <= in_meta;
    end
  end

  assign out_valid = valid_r;
  assign out_vec   = vec_r;
  assign out_meta  = meta_r;

endmodule

// ===== rtl/vaxr_rot.sv =====
module vaxr_rot #(
  parameter int CW = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  vaxr_pkg::axis_t                       axis,
  input  logic signed [vaxr_pkg::COEF_W-1:0]    coef_c,
  input  logic signed [vaxr_pkg::COEF_W-1:0]    coef_s,
  input  logic signed [CW-1:0]                  in_x,
  input  logic signed [CW-1:0]                  in_y,
  input  logic signed [CW-1:0]                  in_z,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [CW-1:0]                  out_x,
  output logic signed [CW-1:0]                  out_y,
  output logic signed [CW-1:0]                  out_z
);

  localparam int KW   = vaxr_pkg::COEF_W;
  localparam int LO_W = CW / 2;
  localparam int HI_W = CW - LO_W;
  localparam int PH_W = HI_W + KW;
  localparam int PL_W = LO_W + 1 + KW;
  localparam int SH_W = PH_W + 1;
  localparam int SL_W = PL_W + 1;
  localparam int TW   = CW + 34;
  localparam int RW   = TW - 30;

  // operand order: lane a (u, v), lane b (u, v)
  logic signed [CW-1:0] op_u [4];
  logic signed [KW-1:0] op_k [4];
  logic signed [KW-1:0] neg_s;
  logic signed [PH_W-1:0] phi_nxt [4];
  logic signed [PL_W-1:0] plo_nxt [4];

  logic                   v1_r, v2_r, v3_r;
  logic                   rdy1, rdy2, rdy3;
  logic signed [PH_W-1:0] phi_r [4];
  logic signed [PL_W-1:0] plo_r [4];
  vaxr_pkg::axis_t        axis1_r, axis2_r;
  logic signed [CW-1:0]   x1_r, y1_r, z1_r, x2_r, y2_r, z2_r;
  logic signed [SH_W-1:0] hsa_r, hsb_r;
  logic signed [SL_W-1:0] lsa_r, lsb_r;
  logic signed [TW-1:0]   ta, tb;
  logic signed [CW-1:0]   ra, rb;
  logic signed [CW-1:0]   ox_nxt, oy_nxt, oz_nxt;
  logic signed [CW-1:0]   ox_r, oy_r, oz_r;

  function automatic logic signed [CW-1:0] sat(input logic signed [RW-1:0] v);
    logic [RW-CW:0] upper;
    upper = v[RW-1:CW-1];
    if ((&upper) || !(|upper)) begin
      return v[CW-1:0];
    end else if (v[RW-1]) begin
      return {1'b1, {(CW-1){1'b0}}};
    end else begin
      return {1'b0, {(CW-1){1'b1}}};
    end
  endfunction

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // stage 1: pick operands per axis, split multiplies
  always_comb begin
    neg_s = -coef_s;
    case (axis)
      vaxr_pkg::AXIS_X: begin
        op_u[0] = in_y; op_k[0] = coef_c; op_u[1] = in_z; op_k[1] = neg_s;
        op_u[2] = in_y; op_k[2] = coef_s; op_u[3] = in_z; op_k[3] = coef_c;
      end
      vaxr_pkg::AXIS_Y: begin
        op_u[0] = in_x; op_k[0] = coef_c; op_u[1] = in_z; op_k[1] = coef_s;
        op_u[2] = in_z; op_k[2] = coef_c; op_u[3] = in_x; op_k[3] = neg_s;
      end
      vaxr_pkg::AXIS_Z: begin
        op_u[0] = in_x; op_k[0] = coef_c; op_u[1] = in_y; op_k[1] = neg_s;
        op_u[2] = in_x; op_k[2] = coef_s; op_u[3] = in_y; op_k[3] = coef_c;
      end
      default: begin
        op_u[0] = '0; op_k[0] = '0; op_u[1] = '0; op_k[1] = '0;
        op_u[2] = '0; op_k[2] = '0; op_u[3] = '0; op_k[3] = '0;
      end
    endcase
  end

  for (genvar k = 0; k < 4; k++) begin : g_mul
    assign phi_nxt[k] = $signed(op_u[k][CW-1:LO_W]) * op_k[k];
    assign plo_nxt[k] = $signed({1'b0, op_u[k][LO_W-1:0]}) * op_k[k];
  end

  // stage 3: recombine halves, round half up, saturate
  always_comb begin
    ta = (TW'(hsa_r) <<< LO_W) + TW'(lsa_r) + TW'(vaxr_pkg::ROUND_Q30);
    tb = (TW'(hsb_r) <<< LO_W) + TW'(lsb_r) + TW'(vaxr_pkg::ROUND_Q30);
    ra = sat(ta[TW-1:30]);
    rb = sat(tb[TW-1:30]);
    ox_nxt = x2_r;
    oy_nxt = y2_r;
    oz_nxt = z2_r;
    case (axis2_r)
      vaxr_pkg::AXIS_X: begin
        oy_nxt = ra;
        oz_nxt = rb;
      end
      vaxr_pkg::AXIS_Y: begin
        ox_nxt = ra;
        oz_nxt = rb;
      end
      vaxr_pkg::AXIS_Z: begin
        ox_nxt = ra;
        oy_nxt = rb;
      end
      default: begin
        ox_nxt = x2_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      phi_r   <= phi_nxt;
      plo_r   <= plo_nxt;
      axis1_r <= axis;
      x1_r    <= in_x;
      y1_r    <= in_y;
      z1_r    <= in_z;
    end
    if (v1_r && rdy2) begin
      hsa_r   <= SH_W'(phi_r[0]) + SH_W'(phi_r[1]);
      hsb_r   <= SH_W'(phi_r[2]) + SH_W'(phi_r[3]);
      lsa_r   <= SL_W'(plo_r[0]) + SL_W'(plo_r[1]);
      lsb_r   <= SL_W'(plo_r[2]) + SL_W'(plo_r[3]);
      axis2_r <= axis1_r;
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
    end
    if (v2_r && rdy3) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
      oz_r <= oz_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_x     = ox_r;
  assign out_y     = oy_r;
  assign out_z     = oz_r;

endmodule

// ===== rtl/vector_axis_rotation_core.sv =====
// channel  dir  handshake      word
// in_ch    in   valid / ready  req_type, angle, in_x, in_y, in_z
// out_ch   out  valid / ready  out_x, out_y, out_z
//
// One vector per cycle sustained while out_ch is ready; registers: one per CORDIC iteration,
// one for the quadrant map, and three for multiply, sum and round/saturate.
// rst_n is synchronous; it clears all stage valid bits, payload is not reset.
// Each stage holds its word while the next one is full and stalled; bubbles
// close up, so the input keeps taking words while a result waits at the output.
module vector_axis_rotation_core #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_WIDTH     = 16,
  parameter int ROTATION_STAGES = 16
) (
  input logic       clk,
  input logic       rst_n,
  vaxr_in_if.sink   in_ch,
  vaxr_out_if.source out_ch
);

  localparam int CW     = COORD_WIDTH;
  localparam int N      = ROTATION_STAGES;
  localparam int META_W = 4 + 3 * CW;
  localparam int KW     = vaxr_pkg::COEF_W;
  localparam int XW     = vaxr_pkg::CX_W;
  localparam logic signed [XW-1:0] ONE_X = XW'(vaxr_pkg::ONE_Q30);

  logic                      chain_valid [N+1];
  logic                      chain_ready [N+1];
  vaxr_pkg::cordic_t         chain_vec   [N+1];
  logic [META_W-1:0]         chain_meta  [N+1];

  logic [vaxr_pkg::TURN_W-1:0] turn;
  logic [vaxr_pkg::TURN_W-1:0] turn_rnd;
  logic [1:0]                  quad;
  logic [vaxr_pkg::TURN_W-1:0] resid;

  logic [META_W-1:0]     tail_meta;
  vaxr_pkg::cordic_t     tail_vec;
  logic signed [XW-1:0]  c_raw, s_raw;
  logic signed [KW-1:0]  c_nxt, s_nxt;

  logic                  map_ready;
  logic                  map_valid_r;
  logic signed [KW-1:0]  map_c_r, map_s_r;
  vaxr_pkg::axis_t       map_axis_r;
  logic signed [CW-1:0]  map_x_r, map_y_r, map_z_r;
  logic                  rot_ready;

  function automatic logic signed [KW-1:0] clamp_q30(input logic signed [XW-1:0] v);
    if (v > ONE_X) begin
      return KW'(ONE_X);
    end else if (v < -ONE_X) begin
      return KW'(-ONE_X);
    end else begin
      return KW'(v);
    end
  endfunction

  // quarter-turn range reduction into the first CORDIC stage
  always_comb begin
    turn     = vaxr_pkg::TURN_W'(in_ch.angle) << (vaxr_pkg::TURN_W - ANGLE_WIDTH);
    turn_rnd = turn + vaxr_pkg::EIGHTH_TURN;
    quad     = turn_rnd[vaxr_pkg::TURN_W-1 -: 2];
    resid    = turn - {quad, {(vaxr_pkg::TURN_W-2){1'b0}}};
    chain_vec[0].x = vaxr_pkg::GAIN_Q30;
    chain_vec[0].y = '0;
    chain_vec[0].z = vaxr_pkg::CZ_W'($signed(resid));
  end

  assign chain_valid[0] = in_ch.valid;
  assign chain_meta[0]  = {quad, in_ch.req_type, in_ch.in_x, in_ch.in_y, in_ch.in_z};
  assign in_ch.ready    = chain_ready[0];

  for (genvar k = 0; k < N; k++) begin : g_cordic
    vaxr_cordic_stage #(
      .STAGE  (k),
      .META_W (META_W)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .in_vec    (chain_vec[k]),
      .in_meta   (chain_meta[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .out_vec   (chain_vec[k+1]),
      .out_meta  (chain_meta[k+1])
    );
  end

  assign tail_vec  = chain_vec[N];
  assign tail_meta = chain_meta[N];

  // map the reduced-angle result back by quadrant, then clamp to +/-1.0
  always_comb begin
    case (vaxr_pkg::quad_t'(tail_meta[META_W-1 -: 2]))
      vaxr_pkg::QUAD_0: begin
        c_raw = tail_vec.x;
        s_raw = tail_vec.y;
      end
      vaxr_pkg::QUAD_90: begin
        c_raw = -tail_vec.y;
        s_raw = tail_vec.x;
      end
      vaxr_pkg::QUAD_180: begin
        c_raw = -tail_vec.x;
        s_raw = -tail_vec.y;
      end
      default: begin
        c_raw = tail_vec.y;
        s_raw = -tail_vec.x;
      end
    endcase
    c_nxt = clamp_q30(c_raw);
    s_nxt = clamp_q30(s_raw);
  end

  assign map_ready        = !map_valid_r || rot_ready;
  assign chain_ready[N]   = map_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= 1'b0;
    end else if (map_ready) begin
      map_valid_r <= chain_valid[N];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[N] && map_ready) begin
      map_c_r    <= c_nxt;
      map_s_r    <= s_nxt;
      map_axis_r <= vaxr_pkg::axis_t'(tail_meta[META_W-3 -: 2]);
      map_x_r    <= tail_meta[3*CW-1 -: CW];
      map_y_r    <= tail_meta[2*CW-1 -: CW];
      map_z_r    <= tail_meta[CW-1:0];
    end
  end

  vaxr_rot #(
    .CW (CW)
  ) u_rot (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (map_valid_r),
    .in_ready  (rot_ready),
    .axis      (map_axis_r),
    .coef_c    (map_c_r),
    .coef_s    (map_s_r),
    .in_x      (map_x_r),
    .in_y      (map_y_r),
    .in_z      (map_z_r),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_x     (out_ch.out_x),
    .out_y     (out_ch.out_y),
    .out_z     (out_ch.out_z)
  );

`ifndef NO_ASSERTIONS
  // a free output lets every stage move, so the input must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.ready |-> in_ch.ready)
    else $error("input stalled while output is free");

  a_coef_range: assert property (@(posedge clk) disable iff (!rst_n)
    map_valid_r |-> (map_c_r <= KW'(ONE_X) && map_c_r >= KW'(-ONE_X) &&
                     map_s_r <= KW'(ONE_X) && map_s_r >= KW'(-ONE_X)))
    else $error("sin/cos coefficient out of range");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_ch.valid)
    else $error("result valid right after reset");

  a_map_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (map_valid_r && !rot_ready) |=> (map_valid_r && $stable(map_c_r) && $stable(map_s_r)))
    else $error("map stage word lost while stalled");
`endif

endmodule
